// ===== rtl/touch_keypad_entry_decoder_macros.svh =====
// Assertion macros shared by the keypad decoder files.
`ifndef TOUCH_KEYPAD_ENTRY_DECODER_MACROS_SVH
`define TOUCH_KEYPAD_ENTRY_DECODER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge outside reset.
`define TKED_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define TKED_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TKED_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TKED_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/tked_pkg.sv =====
`timescale 1ns / 1ps

package tked_pkg;

    localparam int COORD_W = 10;
    localparam int CHAR_W  = 6;
    localparam int DIGIT_W = 4;
    localparam int BOUND_W = 11;
    localparam int CFG_IDX_W = 4;

    localparam logic [DIGIT_W-1:0] EMPTY_DIGIT = 4'd10;
    localparam logic [DIGIT_W-1:0] ROW2_BASE   = 4'd5;

    localparam logic [BOUND_W-1:0] ROW_GAP   = 11'd25;
    localparam logic [BOUND_W-1:0] ROW_SPLIT = 11'd12;
    localparam logic [BOUND_W-1:0] KEY_SPAN  = 11'd12;

    localparam int NUM_COLS = 5;
    localparam logic [BOUND_W-1:0] COL_END [NUM_COLS] = '{11'd2, 11'd5, 11'd8, 11'd11, 11'd14};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEFT     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TOP      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_WIDTH   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_HEIGHT  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_LEFT   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_TOP    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_WIDTH  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_HEIGHT = 4'd7;

    // Register values after reset.
    localparam logic [COORD_W-1:0] RST_KEY_LEFT     = 10'd20;
    localparam logic [COORD_W-1:0] RST_KEY_TOP      = 10'd230;
    localparam logic [CHAR_W-1:0]  RST_CHAR_WIDTH   = 6'd11;
    localparam logic [CHAR_W-1:0]  RST_CHAR_HEIGHT  = 6'd16;
    localparam logic [COORD_W-1:0] RST_ERASE_LEFT   = 10'd174;
    localparam logic [COORD_W-1:0] RST_ERASE_TOP    = 10'd230;
    localparam logic [COORD_W-1:0] RST_ERASE_WIDTH  = 10'd57;
    localparam logic [COORD_W-1:0] RST_ERASE_HEIGHT = 10'd55;

endpackage

// ===== rtl/tked_ram.sv =====
`timescale 1ns / 1ps

module tked_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tked_region_lock.sv =====
`timescale 1ns / 1ps
`include "touch_keypad_entry_decoder_macros.svh"

module tked_region_lock #(
    parameter int DEBOUNCE_RELEASES = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_step,
    input  logic i_touched,
    input  logic i_in_bounds,
    output logic o_press
);

    localparam int DB_W = $clog2(DEBOUNCE_RELEASES + 1);
    localparam logic [DB_W-1:0] DB_LOAD = DB_W'(DEBOUNCE_RELEASES);

    logic            r_locked;
    logic [DB_W-1:0] r_left;
    logic            n_locked;
    logic [DB_W-1:0] n_left;
    logic [DB_W-1:0] s_dec;

    assign o_press = !r_locked && i_touched && i_in_bounds;

    always_comb begin
        n_locked = r_locked;
        n_left   = r_left;
        s_dec    = r_left;
        if (r_locked) begin
            if (!i_touched && r_left != '0) begin
                s_dec = r_left - 1'b1;
            end
            // The countdown reloads in the same step that it unlocks the region.
            if (s_dec == '0) begin
                n_locked = 1'b0;
                n_left   = DB_LOAD;
            end else begin
                n_left = s_dec;
            end
        end else if (o_press) begin
            n_locked = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked <= 1'b0;
            r_left   <= DB_LOAD;
        end else if (i_step) begin
            r_locked <= n_locked;
            r_left   <= n_left;
        end
    end

    `TKED_ASSERT_IMP(a_left_nonzero, i_clk, i_rst_n, 1'b1, r_left != '0)
    `TKED_ASSERT_IMP(a_idle_full_count, i_clk, i_rst_n, !r_locked, r_left == DB_LOAD)
    `TKED_ASSERT_NXT(a_press_locks, i_clk, i_rst_n, i_step && o_press, r_locked)

endmodule

// ===== rtl/touch_keypad_entry_decoder.sv =====
`timescale 1ns / 1ps
`include "touch_keypad_entry_decoder_macros.svh"

// Touch keypad entry decoder. One touch sample can be taken in every clock cycle,
// and each yields exactly one result, which moves from the input register to the
// output register. The sample sits in the input register while the keypad and
// backspace hit tests, the debounce countdowns and the entry length update run,
// and the result is held in the output register. While a result waits to be
// taken, one more sample can still enter the input register. Once both registers
// are full, the input stalls until the result is taken.
// The digit store is a small RAM with a registered read port; the read at
// read_index is issued at the input transfer, and a digit written by the
// sample just ahead is forwarded. Stored positions at or beyond the entry
// length are reported as 10, so the store needs no clearing after reset.
// Configuration writes are taken in every cycle and must only be made while
// no sample is in flight.
module touch_keypad_entry_decoder
    import tked_pkg::*;
#(
    parameter int ENTRY_DEPTH       = 16,
    parameter int DEBOUNCE_RELEASES = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_W-1:0]   i_cfg_data,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_touched,
    input  logic [COORD_W-1:0]   i_touch_x,
    input  logic [COORD_W-1:0]   i_touch_y,
    input  logic [3:0]           i_read_index,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_key_hit,
    output logic [DIGIT_W-1:0]   o_key_digit,
    output logic                 o_key_stored,
    output logic                 o_erase_hit,
    output logic                 o_digit_removed,
    output logic [4:0]           o_entry_count,
    output logic [DIGIT_W-1:0]   o_read_digit
);

    localparam int CW    = $clog2(ENTRY_DEPTH + 1);
    localparam int AW    = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
    localparam int CMP_W = (CW > 4) ? CW : 4;
    localparam logic [CW-1:0] DEPTH_C = CW'(ENTRY_DEPTH);

    // Configuration registers
    logic [COORD_W-1:0] r_key_left, r_key_top, r_erase_left, r_erase_top;
    logic [COORD_W-1:0] r_erase_width, r_erase_height;
    logic [CHAR_W-1:0]  r_char_width, r_char_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_left     <= RST_KEY_LEFT;
            r_key_top      <= RST_KEY_TOP;
            r_char_width   <= RST_CHAR_WIDTH;
            r_char_height  <= RST_CHAR_HEIGHT;
            r_erase_left   <= RST_ERASE_LEFT;
            r_erase_top    <= RST_ERASE_TOP;
            r_erase_width  <= RST_ERASE_WIDTH;
            r_erase_height <= RST_ERASE_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KEY_LEFT:     r_key_left     <= i_cfg_data;
                CFG_KEY_TOP:      r_key_top      <= i_cfg_data;
                CFG_CHAR_WIDTH:   r_char_width   <= i_cfg_data[CHAR_W-1:0];
                CFG_CHAR_HEIGHT:  r_char_height  <= i_cfg_data[CHAR_W-1:0];
                CFG_ERASE_LEFT:   r_erase_left   <= i_cfg_data;
                CFG_ERASE_TOP:    r_erase_top    <= i_cfg_data;
                CFG_ERASE_WIDTH:  r_erase_width  <= i_cfg_data;
                CFG_ERASE_HEIGHT: r_erase_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register and handshake
    logic               r_s1_vld;
    logic               r_s1_touched;
    logic [COORD_W-1:0] r_s1_x, r_s1_y;
    logic [3:0]         r_s1_ridx;
    logic               r_out_vld;
    logic               s_in_xfer, s_advance;

    assign s_advance  = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s_advance;
    assign s_in_xfer  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_in_xfer) begin
            r_s1_vld <= 1'b1;
        end else if (s_advance) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_xfer) begin
            r_s1_touched <= i_touched;
            r_s1_x       <= i_touch_x;
            r_s1_y       <= i_touch_y;
            r_s1_ridx    <= i_read_index;
        end
    end

    // Keypad hit test and digit decode
    logic [BOUND_W-1:0] s_x, s_y, s_kl, s_kt, s_cw, s_ch;
    logic [BOUND_W-1:0] s_key_bot, s_key_right, s_row_split;
    logic [NUM_COLS-1:0] s_col_lt;
    logic               s_key_in, s_col_any;
    logic [DIGIT_W-1:0] s_col, s_digit;

    always_comb begin
        s_x  = BOUND_W'(r_s1_x);
        s_y  = BOUND_W'(r_s1_y);
        s_kl = BOUND_W'(r_key_left);
        s_kt = BOUND_W'(r_key_top);
        s_cw = BOUND_W'(r_char_width);
        s_ch = BOUND_W'(r_char_height);
        s_key_bot   = s_kt + (s_ch << 1) + ROW_GAP;
        s_key_right = s_kl + s_cw * KEY_SPAN;
        s_row_split = s_kt + ROW_SPLIT + s_ch;
        for (int c = 0; c < NUM_COLS; c++) begin
            s_col_lt[c] = s_x < s_kl + s_cw * COL_END[c];
        end
        s_key_in = (s_y >= s_kt) && (s_y <= s_key_bot) && (s_x >= s_kl) && (s_x <= s_key_right);
        s_col_any = |s_col_lt;
        // The leftmost column whose right end lies past x wins.
        priority if (s_col_lt[0]) s_col = 4'd0;
        else if (s_col_lt[1])     s_col = 4'd1;
        else if (s_col_lt[2])     s_col = 4'd2;
        else if (s_col_lt[3])     s_col = 4'd3;
        else                      s_col = 4'd4;
        s_digit = (s_y < s_row_split) ? s_col : s_col + ROW2_BASE;
    end

    // Backspace hit test
    logic s_erase_in;

    always_comb begin
        s_erase_in = (s_x >= BOUND_W'(r_erase_left))
                  && (s_x <= BOUND_W'(r_erase_left) + BOUND_W'(r_erase_width))
                  && (s_y >= BOUND_W'(r_erase_top))
                  && (s_y <= BOUND_W'(r_erase_top) + BOUND_W'(r_erase_height));
    end

    logic s_key_press, s_erase_press;

    tked_region_lock #(
        .DEBOUNCE_RELEASES (DEBOUNCE_RELEASES)
    ) u_key_lock (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s_advance),
        .i_touched   (r_s1_touched),
        .i_in_bounds (s_key_in),
        .o_press     (s_key_press)
    );

    tked_region_lock #(
        .DEBOUNCE_RELEASES (DEBOUNCE_RELEASES)
    ) u_erase_lock (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s_advance),
        .i_touched   (r_s1_touched),
        .i_in_bounds (s_erase_in),
        .o_press     (s_erase_press)
    );

    // Entry length and store
    logic [CW-1:0]      r_len;
    logic [CW-1:0]      s_len_k, s_len_next;
    logic               s_key_hit, s_key_stored, s_removed;
    logic               s_wr_en;
    logic [AW-1:0]      s_wr_addr, s_rd_addr;
    logic [DIGIT_W-1:0] s_ram_rdata, s_mem_digit, s_read_digit;
    logic               r_byp;
    logic [DIGIT_W-1:0] r_byp_data;

    assign s_key_hit    = s_key_press && s_col_any;
    assign s_key_stored = s_key_hit && (r_len < DEPTH_C);
    assign s_len_k      = r_len + CW'(s_key_stored);
    assign s_removed    = s_erase_press && (s_len_k != '0);
    assign s_len_next   = s_len_k - CW'(s_removed);

    assign s_wr_en   = s_advance && s_key_stored;
    assign s_wr_addr = AW'(r_len);
    assign s_rd_addr = AW'(i_read_index);

    tked_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (ENTRY_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s_wr_en),
        .i_waddr (s_wr_addr),
        .i_wdata (s_digit),
        .i_re    (s_in_xfer),
        .i_raddr (s_rd_addr),
        .o_rdata (s_ram_rdata)
    );

    // A read issued in the same cycle as a write to that entry sees old data,
    // so the written digit is kept aside and used instead.
    always_ff @(posedge i_clk) begin
        if (s_in_xfer) begin
            r_byp      <= s_wr_en && (s_wr_addr == s_rd_addr);
            r_byp_data <= s_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (s_advance) begin
            r_len <= s_len_next;
        end
    end

    always_comb begin
        s_mem_digit = r_byp ? r_byp_data : s_ram_rdata;
        // A digit appended by this sample is not in the RAM yet.
        if (s_key_stored && (CMP_W'(r_s1_ridx) == CMP_W'(r_len))) begin
            s_mem_digit = s_digit;
        end
        if ((CMP_W'(r_s1_ridx) < CMP_W'(s_len_next)) && (CMP_W'(r_s1_ridx) < CMP_W'(DEPTH_C))) begin
            s_read_digit = s_mem_digit;
        end else begin
            s_read_digit = EMPTY_DIGIT;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    logic               r_key_hit, r_key_stored, r_erase_hit, r_removed;
    logic [DIGIT_W-1:0] r_key_digit, r_read_digit;
    logic [4:0]         r_entry_count;

    always_ff @(posedge i_clk) begin
        if (s_advance) begin
            r_key_hit     <= s_key_hit;
            r_key_digit   <= s_key_hit ? s_digit : '0;
            r_key_stored  <= s_key_stored;
            r_erase_hit   <= s_erase_press;
            r_removed     <= s_removed;
            r_entry_count <= 5'(s_len_next);
            r_read_digit  <= s_read_digit;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_key_hit       = r_key_hit;
    assign o_key_digit     = r_key_digit;
    assign o_key_stored    = r_key_stored;
    assign o_erase_hit     = r_erase_hit;
    assign o_digit_removed = r_removed;
    assign o_entry_count   = r_entry_count;
    assign o_read_digit    = r_read_digit;

    `TKED_ASSERT_IMP(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= DEPTH_C)
    `TKED_ASSERT_NXT(a_len_hold, i_clk, i_rst_n, !s_advance, $stable(r_len))
    `TKED_ASSERT_NXT(a_len_append, i_clk, i_rst_n, s_advance && s_key_stored && !s_removed, r_len == CW'($past(r_len) + 1'b1))
    `TKED_ASSERT_IMP(a_removed_has_hit, i_clk, i_rst_n, s_removed, s_erase_press && s_len_k != '0)

endmodule

// ===== bench/touch_keypad_entry_decoder_tb.sv =====
`timescale 1ns / 1ps

module touch_keypad_entry_decoder_tb;
    import tked_pkg::*;

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 6;
    localparam int STORE_DEPTH    = 16;
    localparam int DEBOUNCE       = 2;
    localparam int PHASES         = 9;
    localparam int PRESSURE_PHASE = 5;
    localparam int PHASE_SAMPLES  = 136;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 4;
    localparam int QUIET_LIMIT    = 2000;

    // Keypad geometry: span in character widths, row gap and split as coordinate offsets.
    localparam int PAD_GAP   = 25;
    localparam int PAD_SPLIT = 12;
    localparam int PAD_SPAN  = 12;
    localparam int PAD_ROW2  = 5;
    localparam int PAD_KEYS  = 5;

    typedef struct packed {
        logic       key_hit;
        logic [3:0] key_digit;
        logic       key_stored;
        logic       erase_hit;
        logic       digit_removed;
        logic [4:0] entry_count;
        logic [3:0] read_digit;
    } touch_result_t;

    typedef struct packed {
        logic          touched;
        logic [9:0]    x;
        logic [9:0]    y;
        logic [3:0]    ridx;
        logic          typed;
        touch_result_t want;
    } sample_row_t;

    localparam touch_result_t NO_CHECK = '0;

    // Reset geometry: keypad x 20..152, y 230..287, lower row from y 258;
    // backspace x 174..231, y 230..285.
    localparam int DIRECTED_COUNT = 25;
    localparam sample_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{1'b0, 10'd0,    10'd0,    4'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 5'd0, 4'd10}},
        '{1'b1, 10'd0,    10'd0,    4'd15, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 5'd0, 4'd10}},
        '{1'b1, 10'd1023, 10'd1023, 4'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 5'd0, 4'd10}},
        '{1'b1, 10'd174,  10'd230,  4'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 1'b1, 1'b0, 5'd0, 4'd10}},
        '{1'b1, 10'd20,   10'd230,  4'd0,  1'b1, '{1'b1, 4'd0, 1'b1, 1'b0, 1'b0, 5'd1, 4'd0}},
        '{1'b1, 10'd20,   10'd230,  4'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 5'd1, 4'd0}},
        '{1'b0, 10'd0,    10'd0,    4'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 5'd1, 4'd0}},
        '{1'b0, 10'd0,    10'd0,    4'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 5'd1, 4'd0}},
        '{1'b1, 10'd152,  10'd287,  4'd1,  1'b1, '{1'b1, 4'd9, 1'b1, 1'b0, 1'b0, 5'd2, 4'd9}},
        '{1'b0, 10'd1023, 10'd1023, 4'd1,  1'b0, NO_CHECK},
        '{1'b0, 10'd0,    10'd0,    4'd1,  1'b0, NO_CHECK},
        '{1'b1, 10'd41,   10'd257,  4'd2,  1'b0, NO_CHECK},
        '{1'b0, 10'd0,    10'd0,    4'd2,  1'b0, NO_CHECK},
        '{1'b0, 10'd0,    10'd0,    4'd2,  1'b0, NO_CHECK},
        '{1'b1, 10'd42,   10'd258,  4'd3,  1'b0, NO_CHECK},
        '{1'b0, 10'd0,    10'd0,    4'd3,  1'b0, NO_CHECK},
        '{1'b0, 10'd0,    10'd0,    4'd3,  1'b0, NO_CHECK},
        '{1'b1, 10'd153,  10'd230,  4'd0,  1'b0, NO_CHECK},
        '{1'b1, 10'd20,   10'd288,  4'd0,  1'b0, NO_CHECK},
        '{1'b1, 10'd19,   10'd230,  4'd0,  1'b0, NO_CHECK},
        '{1'b1, 10'd231,  10'd285,  4'd3,  1'b0, NO_CHECK},
        '{1'b0, 10'd0,    10'd0,    4'd0,  1'b0, NO_CHECK},
        '{1'b0, 10'd0,    10'd0,    4'd0,  1'b0, NO_CHECK},
        '{1'b1, 10'd232,  10'd286,  4'd0,  1'b0, NO_CHECK},
        '{1'b1, 10'd108,  10'd258,  4'd15, 1'b0, NO_CHECK}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COORD_W-1:0]   i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_touched;
    logic [COORD_W-1:0]   i_touch_x;
    logic [COORD_W-1:0]   i_touch_y;
    logic [3:0]           i_read_index;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_key_hit;
    logic [DIGIT_W-1:0]   o_key_digit;
    logic                 o_key_stored;
    logic                 o_erase_hit;
    logic                 o_digit_removed;
    logic [4:0]           o_entry_count;
    logic [DIGIT_W-1:0]   o_read_digit;

    // Geometry and state as the decoder should hold them.
    logic [9:0] geo_key_left, geo_key_top, geo_erase_left, geo_erase_top;
    logic [9:0] geo_erase_w, geo_erase_h;
    logic [5:0] geo_char_w, geo_char_h;
    bit         pad_locked, bs_locked;
    int         pad_left, bs_left;
    int         digits_held;
    logic [3:0] held_digits [STORE_DEPTH];

    touch_result_t touch_reports_due [$];
    int mismatches = 0;
    int samples_sent = 0;
    int quiet_cycles = 0;
    int in_gap_pct = 15;
    int out_stall_pct = 15;
    int erase_pct = 20;
    bit hold_out = 1'b0;

    touch_keypad_entry_decoder #(
        .ENTRY_DEPTH      (STORE_DEPTH),
        .DEBOUNCE_RELEASES(DEBOUNCE)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_touched      (i_touched),
        .i_touch_x      (i_touch_x),
        .i_touch_y      (i_touch_y),
        .i_read_index   (i_read_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_key_hit      (o_key_hit),
        .o_key_digit    (o_key_digit),
        .o_key_stored   (o_key_stored),
        .o_erase_hit    (o_erase_hit),
        .o_digit_removed(o_digit_removed),
        .o_entry_count  (o_entry_count),
        .o_read_digit   (o_read_digit)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [9:0] clip(int v);
        return (v < 0) ? 10'd0 : (v > 1023) ? 10'd1023 : 10'(v);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic reset_geometry();
        geo_key_left   = 10'd20;
        geo_key_top    = 10'd230;
        geo_char_w     = 6'd11;
        geo_char_h     = 6'd16;
        geo_erase_left = 10'd174;
        geo_erase_top  = 10'd230;
        geo_erase_w    = 10'd57;
        geo_erase_h    = 10'd55;
        pad_locked     = 1'b0;
        bs_locked      = 1'b0;
        pad_left       = DEBOUNCE;
        bs_left        = DEBOUNCE;
        digits_held    = 0;
    endtask

    // A locked region counts untouched samples down and unlocks at zero.
    task automatic tick_release(inout bit locked, inout int left, input bit t);
        if (!t && left > 0)
            left--;
        if (left == 0) begin
            locked = 1'b0;
            left   = DEBOUNCE;
        end
    endtask

    task automatic decode_touch(input bit t, input logic [9:0] x, input logic [9:0] y,
                                input logic [3:0] ridx, output touch_result_t r);
        int xi, yi, kl, kt, cw, ch, el, et, col;
        xi  = x;
        yi  = y;
        kl  = geo_key_left;
        kt  = geo_key_top;
        cw  = geo_char_w;
        ch  = geo_char_h;
        el  = geo_erase_left;
        et  = geo_erase_top;
        col = -1;
        r   = '0;
        if (pad_locked) begin
            tick_release(pad_locked, pad_left, t);
        end else if (t && yi >= kt && yi <= kt + 2 * ch + PAD_GAP &&
                     xi >= kl && xi <= kl + PAD_SPAN * cw) begin
            // Key columns end at 2, 5, 8, 11 and 14 character widths.
            for (int c = 0; c < PAD_KEYS; c++)
                if (col < 0 && xi < kl + (3 * c + 2) * cw)
                    col = c;
            if (col >= 0) begin
                r.key_hit   = 1'b1;
                r.key_digit = 4'(col + ((yi < kt + PAD_SPLIT + ch) ? 0 : PAD_ROW2));
                if (digits_held < STORE_DEPTH) begin
                    held_digits[digits_held] = r.key_digit;
                    digits_held++;
                    r.key_stored = 1'b1;
                end
            end
            pad_locked = 1'b1;
        end
        if (bs_locked) begin
            tick_release(bs_locked, bs_left, t);
        end else if (t && xi >= el && xi <= el + int'(geo_erase_w) &&
                     yi >= et && yi <= et + int'(geo_erase_h)) begin
            bs_locked   = 1'b1;
            r.erase_hit = 1'b1;
            if (digits_held > 0) begin
                digits_held--;
                r.digit_removed = 1'b1;
            end
        end
        r.entry_count = 5'(digits_held);
        r.read_digit  = (ridx < digits_held) ? held_digits[ridx] : EMPTY_DIGIT;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [9:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_KEY_LEFT:     geo_key_left   = data;
            CFG_KEY_TOP:      geo_key_top    = data;
            CFG_CHAR_WIDTH:   geo_char_w     = data[5:0];
            CFG_CHAR_HEIGHT:  geo_char_h     = data[5:0];
            CFG_ERASE_LEFT:   geo_erase_left = data;
            CFG_ERASE_TOP:    geo_erase_top  = data;
            CFG_ERASE_WIDTH:  geo_erase_w    = data;
            CFG_ERASE_HEIGHT: geo_erase_h    = data;
            default: ;
        endcase
    endtask

    task automatic send_sample(input bit t, input logic [9:0] x, input logic [9:0] y,
                               input logic [3:0] ridx, input bit typed,
                               input touch_result_t want);
        touch_result_t r;
        if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_touched    <= t;
        i_touch_x    <= x;
        i_touch_y    <= y;
        i_read_index <= ridx;
        do @(posedge i_clk); while (!o_in_ready);
        decode_touch(t, x, y, ridx, r);
        touch_reports_due.push_back(typed ? want : r);
        samples_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (touch_reports_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Points on and just beside the borders of both regions and the key splits.
    function automatic logic [9:0] fence_coord(bit vertical);
        int k, span, e, es, split;
        k     = vertical ? int'(geo_key_top) : int'(geo_key_left);
        span  = vertical ? 2 * int'(geo_char_h) + PAD_GAP : PAD_SPAN * int'(geo_char_w);
        e     = vertical ? int'(geo_erase_top) : int'(geo_erase_left);
        es    = vertical ? int'(geo_erase_h) : int'(geo_erase_w);
        split = vertical ? k + PAD_SPLIT + int'(geo_char_h)
                         : k + (3 * $urandom_range(0, PAD_KEYS - 1) + 2) * int'(geo_char_w);
        case ($urandom_range(0, 9))
            0: return clip(k - 1);
            1: return clip(k);
            2: return clip(k + span);
            3: return clip(k + span + 1);
            4: return clip(e - 1);
            5: return clip(e);
            6: return clip(e + es);
            7: return clip(e + es + 1);
            8: return clip(split - 1);
            default: return clip(split);
        endcase
    endfunction

    // Either one random sample, or one press with optional held samples, then a run of lifted samples.
    task automatic play_gesture();
        int pick, holds, lifts;
        logic [9:0] x, y;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            send_sample(1'($urandom), 10'($urandom), 10'($urandom), 4'($urandom), 1'b0,
                        NO_CHECK);
        end else begin
            if (pick < 30) begin
                x = fence_coord(1'b0);
                y = fence_coord(1'b1);
            end else if (pick < 30 + erase_pct) begin
                x = clip(int'(geo_erase_left) + $urandom_range(0, int'(geo_erase_w)));
                y = clip(int'(geo_erase_top) + $urandom_range(0, int'(geo_erase_h)));
            end else begin
                x = clip(int'(geo_key_left) + $urandom_range(0, PAD_SPAN * int'(geo_char_w)));
                y = clip(int'(geo_key_top) +
                         $urandom_range(0, 2 * int'(geo_char_h) + PAD_GAP));
            end
            holds = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            // A short release now and then, so that the next press is bounced.
            lifts = ($urandom_range(0, 4) == 0) ? $urandom_range(0, DEBOUNCE - 1)
                                                : $urandom_range(DEBOUNCE, DEBOUNCE + 1);
            send_sample(1'b1, x, y, 4'($urandom), 1'b0, NO_CHECK);
            repeat (holds) send_sample(1'b1, x, y, 4'($urandom), 1'b0, NO_CHECK);
            repeat (lifts)
                send_sample(1'b0, 10'($urandom), 10'($urandom), 4'($urandom), 1'b0, NO_CHECK);
        end
    endtask

    task automatic program_geometry(int phase);
        logic [9:0] vals [CFG_ERASE_HEIGHT + 1];
        int kl, kt, cw, ch, stray_at;
        kl = $urandom_range(0, 700);
        kt = $urandom_range(0, 800);
        cw = $urandom_range(1, 30);
        ch = $urandom_range(1, 40);
        vals[CFG_KEY_LEFT]     = 10'(kl);
        vals[CFG_KEY_TOP]      = 10'(kt);
        vals[CFG_CHAR_WIDTH]   = 10'($urandom);
        vals[CFG_CHAR_HEIGHT]  = 10'($urandom);
        vals[CFG_ERASE_LEFT]   = 10'($urandom);
        vals[CFG_ERASE_TOP]    = 10'($urandom);
        vals[CFG_ERASE_WIDTH]  = 10'($urandom_range(0, 300));
        vals[CFG_ERASE_HEIGHT] = 10'($urandom_range(0, 300));
        case (phase)
            1: begin
                vals[CFG_KEY_LEFT]     = 10'd0;
                vals[CFG_KEY_TOP]      = 10'd0;
                vals[CFG_CHAR_WIDTH]   = 10'd1;
                vals[CFG_CHAR_HEIGHT]  = 10'd1;
                vals[CFG_ERASE_LEFT]   = 10'd0;
                vals[CFG_ERASE_TOP]    = 10'd0;
                vals[CFG_ERASE_WIDTH]  = 10'd0;
                vals[CFG_ERASE_HEIGHT] = 10'd0;
            end
            2: begin
                vals[CFG_KEY_LEFT]     = 10'd1023;
                vals[CFG_KEY_TOP]      = 10'd1023;
                vals[CFG_CHAR_WIDTH]   = 10'd63;
                vals[CFG_CHAR_HEIGHT]  = 10'd63;
                vals[CFG_ERASE_LEFT]   = 10'd1023;
                vals[CFG_ERASE_TOP]    = 10'd1023;
                vals[CFG_ERASE_WIDTH]  = 10'd1023;
                vals[CFG_ERASE_HEIGHT] = 10'd1023;
            end
            3: begin
                // The character width register keeps six bits, so 64 is stored as zero.
                vals[CFG_CHAR_WIDTH]  = 10'd64;
                vals[CFG_CHAR_HEIGHT] = 10'd0;
            end
            4: begin
                vals[CFG_CHAR_WIDTH]   = 10'(cw);
                vals[CFG_CHAR_HEIGHT]  = 10'(ch);
                vals[CFG_ERASE_LEFT]   = 10'(kl + $urandom_range(0, PAD_SPAN * cw));
                vals[CFG_ERASE_TOP]    = 10'(kt);
                vals[CFG_ERASE_WIDTH]  = 10'(PAD_SPAN * cw);
                vals[CFG_ERASE_HEIGHT] = 10'(2 * ch + PAD_GAP);
            end
            default: ;
        endcase
        stray_at = $urandom_range(CFG_KEY_LEFT, CFG_ERASE_HEIGHT);
        for (int i = CFG_KEY_LEFT; i <= CFG_ERASE_HEIGHT; i++) begin
            if (i == stray_at)
                write_register(CFG_IDX_W'($urandom_range(CFG_ERASE_HEIGHT + 1,
                                                         (1 << CFG_IDX_W) - 1)),
                               10'($urandom));
            write_register(CFG_IDX_W'(i), vals[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 30;
        endcase
    endfunction

    initial begin
        int target;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_KEY_LEFT;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_touched    = 1'b0;
        i_touch_x    = '0;
        i_touch_y    = '0;
        i_read_index = '0;
        i_out_ready  = 1'b0;
        reset_geometry();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < DIRECTED_COUNT; n++)
            send_sample(DIRECTED_ROWS[n].touched, DIRECTED_ROWS[n].x, DIRECTED_ROWS[n].y,
                        DIRECTED_ROWS[n].ridx, DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].want);

        for (int phase = 1; phase <= PHASES; phase++) begin
            settle();
            program_geometry(phase);
            erase_pct = $urandom_range(5, 55);
            if (phase == PHASES) begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
            end else begin
                in_gap_pct    = pick_idle_pct();
                out_stall_pct = pick_idle_pct();
            end
            if (phase == PRESSURE_PHASE)
                hold_out = 1'b1;
            target = samples_sent + PHASE_SAMPLES;
            while (samples_sent < target)
                play_gesture();
        end
        settle();

        if (mismatches == 0)
            $display("** touch_keypad_entry_decoder: PASSED **");
        else
            $display("** touch_keypad_entry_decoder: FAILED **");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off so that the decoder fills up.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
            end else if (hold_out) begin
                hold_out = 1'b0;
                stall    = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
                stall = $urandom_range(0, 12);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        touch_result_t due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (touch_reports_due.size() == 0) begin
                $error("result transfer with no sample outstanding");
                mismatches++;
            end else begin
                due = touch_reports_due.pop_front();
                check_field("key_hit", due.key_hit, o_key_hit);
                check_field("key_digit", due.key_digit, o_key_digit);
                check_field("key_stored", due.key_stored, o_key_stored);
                check_field("erase_hit", due.erase_hit, o_erase_hit);
                check_field("digit_removed", due.digit_removed, o_digit_removed);
                check_field("entry_count", due.entry_count, o_entry_count);
                check_field("read_digit", due.read_digit, o_read_digit);
            end
        end
    end

    // Ends the run if no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** touch_keypad_entry_decoder: FAILED **");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tked_pkg.sv
rtl/tked_ram.sv
rtl/tked_region_lock.sv
rtl/touch_keypad_entry_decoder.sv
bench/touch_keypad_entry_decoder_tb.sv
